### design/lqpg_pkg.sv
// ---------------------------------------------------------------------------
// lqpg_pkg: shared types and constants of the lens phase generator
// Holds the fixed-point widths, the polynomial divider reciprocals, the
// register map codes and the structs that pass between the pipeline parts.
// ---------------------------------------------------------------------------
package lqpg_pkg;

	// Largest grid side and result width.
	localparam int MAX_DIM  = 1024;
	localparam int OUT_BITS = 16;

	// Widths of the centered offsets and of their squares.
	localparam int SPAN_W = $clog2(MAX_DIM);
	localparam int OFS_W  = (SPAN_W > 11) ? SPAN_W : 11;
	localparam int SQ_W   = 2 * OFS_W;

	// Aperture sum width and the width of its compare against the limit.
	localparam int AP_W  = 33 + SQ_W;
	localparam int LIM_W = 56;
	localparam int CMP_W = (AP_W > LIM_W) ? AP_W : LIM_W;

	// Q30 angle and polynomial term widths.
	localparam int A_W = 30;
	localparam int T_W = 31;
	localparam logic [T_W-1:0] Q30_ONE = T_W'(1) << 30;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// Horner steps: the cosine uses all six, the sine five plus its final
	// multiply by the angle.
	localparam int HORNER_STEPS = 6;
	localparam int SIN_TERMS    = 5;

	// Exact truncating division of a 30-bit value by k is a multiply by
	// ceil(2^S / k) and a right shift by S, where S = 30 + ceil(log2(k)).
	localparam int unsigned SIN_SH [SIN_TERMS] = '{37, 37, 36, 35, 33};
	localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{
		32'(((64'd1 << 37) + 64'd109) / 64'd110),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6)
	};
	localparam int unsigned COS_SH [HORNER_STEPS] = '{38, 37, 36, 35, 34, 31};
	localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
		32'(((64'd1 << 38) + 64'd131) / 64'd132),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 31) + 64'd1) / 64'd2)
	};

	// Pipeline depth of each part.
	localparam int GEOM_STAGES = 8;
	localparam int POLY_STAGES = 2 * HORNER_STEPS;
	localparam int OUT_STAGES  = 2;
	localparam int PIPE_STAGES = GEOM_STAGES + POLY_STAGES + OUT_STAGES;

	// Configuration port.
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_PHASE_COEF_X,
		REG_PHASE_COEF_Y,
		REG_APERTURE_COEF_X,
		REG_APERTURE_COEF_Y,
		REG_APERTURE_LIMIT
	} lqpg_reg_t;

	// Quadrant of the wrapped phase, each a quarter turn wide.
	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} lqpg_quad_t;

	typedef struct packed {
		logic [10:0]      grid_width;
		logic [10:0]      grid_height;
		logic [31:0]      phase_coef_x;
		logic [31:0]      phase_coef_y;
		logic [31:0]      aperture_coef_x;
		logic [31:0]      aperture_coef_y;
		logic [LIM_W-1:0] aperture_limit;
	} lqpg_cfg_t;

	// Per-word side information carried beside the angle.
	typedef struct packed {
		lqpg_quad_t quad;
		logic       neg;
		logic       in_aperture;
	} lqpg_side_t;

endpackage

### design/lqpg_regs.sv
// ---------------------------------------------------------------------------
// lqpg_regs: configuration register file
// APB-style slave holding the grid size, phase and aperture registers.
// Registers sit at byte address 8*index; writes complete in the access cycle.
// ---------------------------------------------------------------------------
module lqpg_regs
	import lqpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output lqpg_cfg_t         cfg
);

	lqpg_cfg_t cfg_q;
	lqpg_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = lqpg_reg_t'(paddr[ADDR_W-1:3]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width      <= 11'd512;
			cfg_q.grid_height     <= 11'd512;
			cfg_q.phase_coef_x    <= '0;
			cfg_q.phase_coef_y    <= '0;
			cfg_q.aperture_coef_x <= 32'd1;
			cfg_q.aperture_coef_y <= 32'd1;
			cfg_q.aperture_limit  <= '1;
		end else if (wr_en) begin
			case (reg_sel)
				REG_GRID_WIDTH:      cfg_q.grid_width      <= pwdata[10:0];
				REG_GRID_HEIGHT:     cfg_q.grid_height     <= pwdata[10:0];
				REG_PHASE_COEF_X:    cfg_q.phase_coef_x    <= pwdata[31:0];
				REG_PHASE_COEF_Y:    cfg_q.phase_coef_y    <= pwdata[31:0];
				REG_APERTURE_COEF_X: cfg_q.aperture_coef_x <= pwdata[31:0];
				REG_APERTURE_COEF_Y: cfg_q.aperture_coef_y <= pwdata[31:0];
				REG_APERTURE_LIMIT:  cfg_q.aperture_limit  <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (reg_sel)
			REG_GRID_WIDTH:      prdata = DATA_W'(cfg_q.grid_width);
			REG_GRID_HEIGHT:     prdata = DATA_W'(cfg_q.grid_height);
			REG_PHASE_COEF_X:    prdata = DATA_W'(cfg_q.phase_coef_x);
			REG_PHASE_COEF_Y:    prdata = DATA_W'(cfg_q.phase_coef_y);
			REG_APERTURE_COEF_X: prdata = DATA_W'(cfg_q.aperture_coef_x);
			REG_APERTURE_COEF_Y: prdata = DATA_W'(cfg_q.aperture_coef_y);
			REG_APERTURE_LIMIT:  prdata = DATA_W'(cfg_q.aperture_limit);
			default:             prdata = '0;
		endcase
	end

endmodule

### design/lqpg_geom.sv
// ---------------------------------------------------------------------------
// lqpg_geom: pixel geometry and phase front end
// Forms the centered half-pixel offsets, their squares, the aperture test,
// the wrapped phase with its quadrant reduction, and the Q30 angle and its
// square. Eight register stages.
// ---------------------------------------------------------------------------
module lqpg_geom
	import lqpg_pkg::*;
(
	input  logic                   clk,
	input  logic [GEOM_STAGES-1:0] en,
	input  lqpg_cfg_t              cfg,
	input  logic [9:0]             row,
	input  logic [9:0]             col,
	output logic [A_W-1:0]         ang,
	output logic [A_W-1:0]         ang_sq,
	output lqpg_side_t             side
);

	// |2*idx - (n-1)| with n saturated to 1 .. MAX_DIM.
	function automatic logic [OFS_W-1:0] half_ofs(input logic [9:0] idx,
		input logic [10:0] n);
		logic [SPAN_W-1:0]  span;
		logic [OFS_W+1:0]   diff;
		if (n == '0) begin
			span = '0;
		end else if (32'(n) > MAX_DIM) begin
			span = SPAN_W'(MAX_DIM - 1);
		end else begin
			span = SPAN_W'(n - 11'd1);
		end
		diff = (OFS_W+2)'({idx, 1'b0}) - (OFS_W+2)'(span);
		return diff[OFS_W+1] ? OFS_W'(-diff) : OFS_W'(diff);
	endfunction

	logic [OFS_W-1:0]  dx_s1, dy_s1;
	logic [SQ_W-1:0]   xsq_s2, ysq_s2;
	logic [AP_W-2:0]   apx_s3, apy_s3;
	logic [31:0]       phx_s3, phy_s3;
	logic [31:0]       phase_s4;
	logic              inside_s4;
	logic [A_W-1:0]    mag_s5;
	lqpg_side_t        side_s5, side_s6, side_s7, side_s8;
	logic [61:0]       angp_s6;
	logic [A_W-1:0]    a_s7, a_s8;
	logic [2*A_W-1:0]  asq_s8;

	logic [AP_W-1:0]   ap_sum;
	logic [31:0]       phase_rot;
	logic [31:0]       phase_red;
	logic [31:0]       phase_abs;
	logic [61:0]       ang_rnd;

	// Stage 1: centered offsets.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= half_ofs(col, cfg.grid_width);
			dy_s1 <= half_ofs(row, cfg.grid_height);
		end
	end

	// Stage 2: squared offsets.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			xsq_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			ysq_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		end
	end

	// Stage 3: weighted terms; the phase keeps only its fraction of a turn.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			apx_s3 <= (AP_W-1)'(cfg.aperture_coef_x) * (AP_W-1)'(xsq_s2);
			apy_s3 <= (AP_W-1)'(cfg.aperture_coef_y) * (AP_W-1)'(ysq_s2);
			phx_s3 <= cfg.phase_coef_x * 32'(xsq_s2);
			phy_s3 <= cfg.phase_coef_y * 32'(ysq_s2);
		end
	end

	// Stage 4: aperture compare and wrapped phase sum.
	assign ap_sum = AP_W'(apx_s3) + AP_W'(apy_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			inside_s4 <= !(CMP_W'(ap_sum) > CMP_W'(cfg.aperture_limit));
			phase_s4  <= phx_s3 + phy_s3;
		end
	end

	// Stage 5: nearest quarter turn and the signed remainder's magnitude.
	assign phase_rot = phase_s4 + 32'h2000_0000;
	assign phase_red = phase_s4 - {phase_rot[31:30], 30'd0};
	assign phase_abs = phase_red[31] ? (32'd0 - phase_red) : phase_red;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mag_s5              <= phase_abs[A_W-1:0];
			side_s5.quad        <= lqpg_quad_t'(phase_rot[31:30]);
			side_s5.neg         <= phase_red[31];
			side_s5.in_aperture <= inside_s4;
		end
	end

	// Stage 6: turns to radians.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			angp_s6 <= 62'(mag_s5) * 62'(PI_Q30);
			side_s6 <= side_s5;
		end
	end

	// Stage 7: round the angle to Q30; it stays at or below pi/4.
	assign ang_rnd = angp_s6 + (62'd1 << 30);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			a_s7    <= ang_rnd[31 +: A_W];
			side_s7 <= side_s6;
		end
	end

	// Stage 8: squared angle.
	always_ff @(posedge clk) begin
		if (en[7]) begin
			asq_s8  <= (2*A_W)'(a_s7) * (2*A_W)'(a_s7);
			a_s8    <= a_s7;
			side_s8 <= side_s7;
		end
	end

	assign ang    = a_s8;
	assign ang_sq = asq_s8[30 +: A_W];
	assign side   = side_s8;

endmodule

### design/lqpg_poly.sv
// ---------------------------------------------------------------------------
// lqpg_poly: cosine and sine polynomial lanes
// Two parallel Horner lanes, one step per pair of stages: a multiply by the
// squared angle, then an exact divide by the step's constant through a
// reciprocal multiply. The sine lane ends in a multiply by the angle.
// ---------------------------------------------------------------------------
module lqpg_poly
	import lqpg_pkg::*;
(
	input  logic                   clk,
	input  logic [POLY_STAGES-1:0] en,
	input  logic [A_W-1:0]         ang,
	input  logic [A_W-1:0]         ang_sq,
	input  lqpg_side_t             side,
	output logic [T_W-1:0]         cos_mag,
	output logic [T_W-1:0]         sin_mag,
	output lqpg_side_t             side_out
);

	logic [A_W-1:0] a_w    [HORNER_STEPS];
	logic [A_W-1:0] a2_w   [HORNER_STEPS];
	lqpg_side_t     side_w [HORNER_STEPS];
	logic [A_W-1:0] cquo_w [HORNER_STEPS];
	logic [A_W-1:0] squo_w [HORNER_STEPS];

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
		logic [A_W-1:0]   a_in, a2_in;
		lqpg_side_t       side_in;
		logic [T_W-1:0]   ct_in, st_in;
		logic [A_W-1:0]   smul_in;
		logic [61:0]      cdiv;
		logic [A_W-1:0]   a_s1, a2_s1, a_s2, a2_s2;
		lqpg_side_t       side_s1, side_s2;
		logic [2*A_W-1:0] cprod_s1, sprod_s1;
		logic [A_W-1:0]   cquo_s2, squo_s2;

		// Previous step's term, or one for the first step.
		if (j == 0) begin : g_first
			assign a_in    = ang;
			assign a2_in   = ang_sq;
			assign side_in = side;
			assign ct_in   = Q30_ONE;
			assign st_in   = Q30_ONE;
		end else begin : g_next
			assign a_in    = a_w[j-1];
			assign a2_in   = a2_w[j-1];
			assign side_in = side_w[j-1];
			assign ct_in   = Q30_ONE - T_W'(cquo_w[j-1]);
			assign st_in   = Q30_ONE - T_W'(squo_w[j-1]);
		end

		// The sine's last step multiplies by the angle instead.
		assign smul_in = (j < SIN_TERMS) ? a2_in : a_in;

		// First stage of the step: product with the running term.
		always_ff @(posedge clk) begin
			if (en[2*j]) begin
				cprod_s1 <= (2*A_W)'(a2_in) * (2*A_W)'(ct_in);
				sprod_s1 <= (2*A_W)'(smul_in) * (2*A_W)'(st_in);
				a_s1     <= a_in;
				a2_s1    <= a2_in;
				side_s1  <= side_in;
			end
		end

		// Second stage of the step: divide by the step's constant (the sine's last step keeps its product).
		assign cdiv = 62'(cprod_s1[30 +: A_W]) * 62'(COS_RCP[j]);

		if (j < SIN_TERMS) begin : g_sdiv
			logic [61:0] sdiv;
			assign sdiv = 62'(sprod_s1[30 +: A_W]) * 62'(SIN_RCP[j]);
			always_ff @(posedge clk) begin
				if (en[2*j+1]) begin
					squo_s2 <= A_W'(sdiv >> SIN_SH[j]);
				end
			end
		end else begin : g_sfin
			always_ff @(posedge clk) begin
				if (en[2*j+1]) begin
					squo_s2 <= sprod_s1[30 +: A_W];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[2*j+1]) begin
				cquo_s2 <= A_W'(cdiv >> COS_SH[j]);
				a_s2    <= a_s1;
				a2_s2   <= a2_s1;
				side_s2 <= side_s1;
			end
		end

		assign a_w[j]    = a_s2;
		assign a2_w[j]   = a2_s2;
		assign side_w[j] = side_s2;
		assign cquo_w[j] = cquo_s2;
		assign squo_w[j] = squo_s2;
	end

	// The cosine is one minus its last quotient; the sine is the final product.
	assign cos_mag  = Q30_ONE - T_W'(cquo_w[HORNER_STEPS-1]);
	assign sin_mag  = T_W'(squo_w[HORNER_STEPS-1]);
	assign side_out = side_w[HORNER_STEPS-1];

endmodule

### design/lqpg_out.sv
// ---------------------------------------------------------------------------
// lqpg_out: output scaling and quadrant mapping
// Scales the Q30 magnitudes to the output amplitude with rounding, then
// applies the quadrant rotation, the remainder's sign and the aperture mask.
// ---------------------------------------------------------------------------
module lqpg_out
	import lqpg_pkg::*;
(
	input  logic                         clk,
	input  logic [OUT_STAGES-1:0]        en,
	input  logic [T_W-1:0]               cos_mag,
	input  logic [T_W-1:0]               sin_mag,
	input  lqpg_side_t                   side,
	output logic signed [OUT_BITS-1:0]   cos_val,
	output logic signed [OUT_BITS-1:0]   sin_val,
	output logic                         inside_res
);

	localparam int SC_W = 30 + OUT_BITS;
	localparam logic [SC_W-1:0] OUT_AMP = SC_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
	localparam logic [SC_W-1:0] ROUND   = SC_W'(1) << 29;

	// Rounded scaling of a Q30 magnitude to the output amplitude.
	function automatic logic [OUT_BITS-2:0] scale(input logic [T_W-1:0] mag);
		logic [SC_W-1:0] prod;
		prod = SC_W'(mag) * OUT_AMP + ROUND;
		return prod[30 +: OUT_BITS-1];
	endfunction

	logic [OUT_BITS-2:0]        cs_s1, sn_s1;
	lqpg_side_t                 side_s1;
	logic signed [OUT_BITS-1:0] cos_s2, sin_s2;
	logic                       inside_s2;

	logic [OUT_BITS-1:0] c_pos, c_neg, s_pos, s_neg;
	logic [OUT_BITS-1:0] cos_map, sin_map;

	// Stage 1: amplitude scaling.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cs_s1   <= scale(cos_mag);
			sn_s1   <= scale(sin_mag);
			side_s1 <= side;
		end
	end

	// The sine follows the sign of the remainder inside its quadrant.
	assign c_pos = {1'b0, cs_s1};
	assign c_neg = '0 - c_pos;
	assign s_pos = side_s1.neg ? ('0 - {1'b0, sn_s1}) : {1'b0, sn_s1};
	assign s_neg = side_s1.neg ? {1'b0, sn_s1} : ('0 - {1'b0, sn_s1});

	// Quadrant rotation of the (cos, sin) pair.
	always_comb begin
		case (side_s1.quad)
			QUAD_0: begin
				cos_map = c_pos;
				sin_map = s_pos;
			end
			QUAD_1: begin
				cos_map = s_neg;
				sin_map = c_pos;
			end
			QUAD_2: begin
				cos_map = c_neg;
				sin_map = s_neg;
			end
			QUAD_3: begin
				cos_map = s_pos;
				sin_map = c_neg;
			end
			default: begin
				cos_map = c_pos;
				sin_map = s_pos;
			end
		endcase
	end

	// Stage 2: output register with the aperture mask.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cos_s2    <= side_s1.in_aperture ? $signed(cos_map) : '0;
			sin_s2    <= side_s1.in_aperture ? $signed(sin_map) : '0;
			inside_s2 <= side_s1.in_aperture;
		end
	end

	assign cos_val    = cos_s2;
	assign sin_val    = sin_s2;
	assign inside_res = inside_s2;

endmodule

### design/lens_quadratic_phase_generator_top.sv
// Depth: 22 register stages between an accepted input word and its result word.
// Throughput: one word per cycle while the output is not stalled; every stage is a register stage of its own.
// A stalled output holds only the stages behind it up to the first empty one.
// Reset clears all stage valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
// lens_quadratic_phase_generator_top: thin-lens phase sample generator
// Maps a pixel (row, col) to the cosine and sine of its quadratic lens phase,
// masked by a circular aperture. Geometry front end, two polynomial lanes and
// an output stage, with per-stage valid bits and a ready chain for stalls.
// ---------------------------------------------------------------------------
module lens_quadratic_phase_generator_top
	import lqpg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [9:0]                 row,
	input  logic [9:0]                 col,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_BITS-1:0] cos_val,
	output logic signed [OUT_BITS-1:0] sin_val,
	output logic                       inside_res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready
);

	lqpg_cfg_t              cfg;
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] stage_en;

	logic [A_W-1:0] ang, ang_sq;
	lqpg_side_t     geom_side, poly_side;
	logic [T_W-1:0] cos_mag, sin_mag;

	// A stage loads when it is empty or when the stage after it loads.
	always_comb begin
		stage_en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !out_stall;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !stage_en[0];
	assign out_valid = vld_q[PIPE_STAGES-1];

	lqpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lqpg_geom u_geom (
		.clk    (clk),
		.en     (stage_en[GEOM_STAGES-1:0]),
		.cfg    (cfg),
		.row    (row),
		.col    (col),
		.ang    (ang),
		.ang_sq (ang_sq),
		.side   (geom_side)
	);

	lqpg_poly u_poly (
		.clk      (clk),
		.en       (stage_en[GEOM_STAGES +: POLY_STAGES]),
		.ang      (ang),
		.ang_sq   (ang_sq),
		.side     (geom_side),
		.cos_mag  (cos_mag),
		.sin_mag  (sin_mag),
		.side_out (poly_side)
	);

	lqpg_out u_out (
		.clk        (clk),
		.en         (stage_en[GEOM_STAGES+POLY_STAGES +: OUT_STAGES]),
		.cos_mag    (cos_mag),
		.sin_mag    (sin_mag),
		.side       (poly_side),
		.cos_val    (cos_val),
		.sin_val    (sin_val),
		.inside_res (inside_res)
	);

endmodule

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the lens quadratic phase generator
// Programs the lens registers through the APB port, feeds pixel words and
// checks every result word against a local fixed-point model of the lens
// transmission. Covers reset values, saturated grid sizes, quadrant edges,
// aperture extremes and randomized lens setups with random stalls and gaps.
// ---------------------------------------------------------------------------
module tb_top
	import lqpg_pkg::*;
();

	// Register index with no register behind it.
	localparam int REG_UNMAPPED = 7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = PIPE_STAGES + 4;

	// Fixed-point constants of the transmission model.
	localparam bit [63:0] UNIT_Q30 = 64'd1 << 30;
	localparam bit [63:0] HALF_PI_STEP = 64'd1 << 29;
	localparam bit [63:0] PI_FIXED = 64'd3373259426;
	localparam bit [63:0] TURN_MASK = 64'hFFFF_FFFF;
	localparam bit [63:0] LIMIT_MAX = (64'd1 << 56) - 64'd1;
	localparam bit [63:0] AMPLITUDE = (64'd1 << (OUT_BITS - 1)) - 64'd1;
	localparam int unsigned SINE_DIVS [5] = '{110, 72, 42, 20, 6};
	localparam int unsigned COSINE_DIVS [6] = '{132, 90, 56, 30, 12, 2};

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] col;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] cos_v;
		logic signed [OUT_BITS-1:0] sin_v;
		logic                       in_aperture;
	} lens_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] row = '0;
	logic [9:0] col = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_BITS-1:0] cos_val;
	logic signed [OUT_BITS-1:0] sin_val;
	logic inside_res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Local copy of the lens registers, already masked to their widths.
	bit [63:0] lens_width = 64'd512;
	bit [63:0] lens_height = 64'd512;
	bit [63:0] lens_phase_x = 64'd0;
	bit [63:0] lens_phase_y = 64'd0;
	bit [63:0] lens_weight_x = 64'd1;
	bit [63:0] lens_weight_y = 64'd1;
	bit [63:0] lens_limit = LIMIT_MAX;

	pixel_t pixel_q[$];
	lens_sample_t sample_q[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	lens_quadratic_phase_generator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row(row),
		.col(col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cos_val(cos_val),
		.sin_val(sin_val),
		.inside_res(inside_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Grid sides saturate to the range 1 .. MAX_DIM.
	function automatic bit [63:0] clamp_side(bit [63:0] n);
		if (n < 64'd1)
			return 64'd1;
		if (n > MAX_DIM)
			return MAX_DIM;
		return n;
	endfunction

	// Square of the centered offset in half-pixel units.
	function automatic bit [63:0] centered_sq(bit [63:0] idx, bit [63:0] n);
		bit [63:0] twice, span, d;
		twice = 64'd2 * idx;
		span = n - 64'd1;
		d = (twice >= span) ? (twice - span) : (span - twice);
		return d * d;
	endfunction

	// Horner evaluation of the truncated Taylor series in Q30.
	function automatic bit [63:0] series_eval(bit [63:0] a2, bit cosine);
		bit [63:0] t;
		int steps;
		int unsigned k;
		t = UNIT_Q30;
		steps = cosine ? 6 : 5;
		for (int i = 0; i < steps; i++) begin
			k = cosine ? COSINE_DIVS[i] : SINE_DIVS[i];
			t = UNIT_Q30 - ((a2 * t) >> 30) / k;
		end
		return t;
	endfunction

	// Scales a Q30 magnitude to the output amplitude and applies the sign.
	function automatic logic signed [OUT_BITS-1:0] to_output(bit [63:0] mag, bit neg);
		bit [63:0] v;
		v = (mag * AMPLITUDE + HALF_PI_STEP) >> 30;
		return neg ? OUT_BITS'(-v) : OUT_BITS'(v);
	endfunction

	// Expected transmission sample of one pixel under the current registers.
	function automatic lens_sample_t lens_transmission(logic [9:0] r, logic [9:0] c);
		lens_sample_t res;
		bit [63:0] xs2, ys2, aperture, p, qv, diff, m, a, a2, s, cs;
		bit neg;
		lqpg_quad_t quad;
		res = '0;
		xs2 = centered_sq(64'(c), clamp_side(lens_width));
		ys2 = centered_sq(64'(r), clamp_side(lens_height));
		aperture = lens_weight_x * xs2 + lens_weight_y * ys2;
		if (aperture > lens_limit)
			return res;
		p = (lens_phase_x * xs2 + lens_phase_y * ys2) & TURN_MASK;
		qv = ((p + HALF_PI_STEP) & TURN_MASK) >> 30;
		quad = lqpg_quad_t'(qv[1:0]);
		diff = (p - (qv << 30)) & TURN_MASK;
		neg = diff[31];
		m = neg ? ((64'd1 << 32) - diff) : diff;
		a = (m * PI_FIXED + UNIT_Q30) >> 31;
		a2 = (a * a) >> 30;
		s = (a * series_eval(a2, 1'b0)) >> 30;
		cs = series_eval(a2, 1'b1);
		case (quad)
			QUAD_0: begin
				res.cos_v = to_output(cs, 1'b0);
				res.sin_v = to_output(s, neg);
			end
			QUAD_1: begin
				res.cos_v = to_output(s, !neg);
				res.sin_v = to_output(cs, 1'b0);
			end
			QUAD_2: begin
				res.cos_v = to_output(cs, 1'b1);
				res.sin_v = to_output(s, !neg);
			end
			default: begin
				res.cos_v = to_output(s, neg);
				res.sin_v = to_output(cs, 1'b1);
			end
		endcase
		res.in_aperture = 1'b1;
		return res;
	endfunction

	// One APB write: setup cycle, access cycle, then the local copy follows.
	task automatic write_reg(int idx, bit [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:      lens_width = value & 64'h7FF;
			REG_GRID_HEIGHT:     lens_height = value & 64'h7FF;
			REG_PHASE_COEF_X:    lens_phase_x = value & TURN_MASK;
			REG_PHASE_COEF_Y:    lens_phase_y = value & TURN_MASK;
			REG_APERTURE_COEF_X: lens_weight_x = value & TURN_MASK;
			REG_APERTURE_COEF_Y: lens_weight_y = value & TURN_MASK;
			REG_APERTURE_LIMIT:  lens_limit = value & LIMIT_MAX;
			default: ;
		endcase
	endtask

	task automatic program_lens(bit [63:0] w, bit [63:0] h, bit [63:0] px, bit [63:0] py,
			bit [63:0] ax, bit [63:0] ay, bit [63:0] lim);
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_PHASE_COEF_X, px);
		write_reg(REG_PHASE_COEF_Y, py);
		write_reg(REG_APERTURE_COEF_X, ax);
		write_reg(REG_APERTURE_COEF_Y, ay);
		write_reg(REG_APERTURE_LIMIT, lim);
	endtask

	// Waits until every queued pixel is sent and every sample has come back.
	task automatic wait_drained();
		while (pixel_q.size() != 0 || in_valid || sample_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_pixel(int r, int c);
		pixel_t px;
		px.row = 10'(r);
		px.col = 10'(c);
		pixel_q = {pixel_q, px};
	endtask

	function automatic bit [63:0] random_side();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return 64'd1;
			2: return MAX_DIM;
			3: return $urandom_range(2047, MAX_DIM + 1);
			default: return $urandom_range(MAX_DIM, 1);
		endcase
	endfunction

	function automatic bit [63:0] random_phase();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return 64'h7FFF_FFFF;
			2: return 64'h8000_0000;
			3: return $urandom_range(1 << 20);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic bit [63:0] random_weight();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return 64'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(16);
		endcase
	endfunction

	// Random lens setup; most limits cut the grid somewhere in its middle.
	task automatic random_setup();
		bit [63:0] w, h, ax, ay, lim, wc, hc, full;
		w = random_side();
		h = random_side();
		if ($urandom_range(9) == 0)
			w |= {$urandom, $urandom} << 11;
		ax = random_weight();
		ay = random_weight();
		wc = clamp_side(w & 64'h7FF);
		hc = clamp_side(h & 64'h7FF);
		full = ax * wc * wc + ay * hc * hc;
		case ($urandom_range(7))
			0: lim = 64'd0;
			1: lim = LIMIT_MAX;
			2: lim = {$urandom, $urandom};
			default: lim = (full / 64) * $urandom_range(64);
		endcase
		program_lens(w, h, random_phase(), random_phase(), ax, ay, lim);
	endtask

	// Random pixels, mostly inside the grid and some anywhere in the field range.
	task automatic queue_random_pixels(int count);
		int r, c;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 15) begin
				r = $urandom_range(1023);
				c = $urandom_range(1023);
			end else begin
				r = $urandom_range(clamp_side(lens_height) - 1);
				c = $urandom_range(clamp_side(lens_width) - 1);
			end
			push_pixel(r, c);
		end
	endtask

	// Sender: computes the expected sample at acceptance and offers the next word.
	always @(posedge clk) begin
		pixel_t next_px;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				sample_q = {sample_q, lens_transmission(row, col)};
			if (!in_valid || !in_stall) begin
				if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
					next_px = pixel_q.pop_front();
					in_valid <= 1'b1;
					row <= next_px.row;
					col <= next_px.col;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(string field, longint want_v, longint got_v);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
	endtask

	// Receiver: checks each accepted result word and stalls at random.
	always @(posedge clk) begin
		lens_sample_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sample_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: result word with no expected sample, expected none, actual %0d %0d %0d",
						$time, cos_val, sin_val, inside_res);
				end else begin
					want = sample_q.pop_front();
					if (cos_val !== want.cos_v)
						flag_mismatch("cos_val", want.cos_v, cos_val);
					if (sin_val !== want.sin_v)
						flag_mismatch("sin_val", want.sin_v, sin_val);
					if (inside_res !== want.in_aperture)
						flag_mismatch("inside_res", want.in_aperture, inside_res);
				end
			end
			out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
		end
	end

	// Watchdog on the run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus sequence: directed corners first, then randomized lens setups.
	initial begin
		bit [63:0] quarter_edges [7];
		quarter_edges = '{64'h2000_0000, 64'h1FFF_FFFF, 64'h4000_0000, 64'h8000_0000,
			64'hC000_0000, 64'hE000_0000, 64'hFFFF_FFFF};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: flat phase, every pixel inside.
		push_pixel(0, 0);
		push_pixel(1023, 1023);
		push_pixel(255, 255);
		push_pixel(256, 256);
		push_pixel(0, 1023);
		push_pixel(1023, 0);
		wait_drained();

		// A write past the register list changes nothing.
		write_reg(REG_UNMAPPED, {$urandom, $urandom});
		push_pixel(0, 0);
		push_pixel(1023, 512);
		wait_drained();

		// Largest grid with extreme phase and aperture weights.
		program_lens(MAX_DIM, MAX_DIM, 64'h7FFF_FFFF, 64'h8000_0000,
			64'hFFFF_FFFF, 64'hFFFF_FFFF, LIMIT_MAX);
		push_pixel(0, 0);
		push_pixel(1023, 1023);
		push_pixel(0, 1023);
		push_pixel(1023, 0);
		wait_drained();

		// Zero grid sides saturate to one; a zero limit keeps only the center.
		program_lens(64'd0, 64'd0, 64'h1234_5678, 64'h9ABC_DEF0, 64'd1, 64'd1, 64'd0);
		push_pixel(0, 0);
		push_pixel(0, 1);
		push_pixel(1, 0);
		wait_drained();

		// Zero aperture weights keep every pixel inside even with a zero limit.
		program_lens(64'd5, 64'd5, 64'h0137_0F01, 64'hF00D_1234, 64'd0, 64'd0, 64'd0);
		push_pixel(1023, 1023);
		push_pixel(2, 2);
		wait_drained();

		// Phases on and next to the quadrant edges, with a unit squared offset.
		foreach (quarter_edges[i]) begin
			program_lens(64'd2, 64'd1, quarter_edges[i], 64'd0, 64'd1, 64'd1, LIMIT_MAX);
			push_pixel(0, 0);
			wait_drained();
		end

		// Randomized lens setups; one of them runs with no gaps or stalls, and
		// each ends with the sender held until all samples are back.
		for (int phase = 0; phase < 16; phase++) begin
			random_setup();
			steady = (phase == 4);
			queue_random_pixels($urandom_range(135, 100));
			wait_drained();
			steady = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
design/lqpg_pkg.sv
design/lqpg_regs.sv
design/lqpg_geom.sv
design/lqpg_poly.sv
design/lqpg_out.sv
design/lens_quadratic_phase_generator_top.sv
verif/tb_top.sv
